FILE: src/skf_pkg.sv
`default_nettype none

package skf_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int VALUE_WIDTH     = 32;
	localparam int GAIN_BITS       = 16;
	localparam int DIFF_WIDTH      = VALUE_WIDTH + 1;
	localparam int GAIN_WIDTH      = GAIN_BITS + 1;
	localparam int PROD_WIDTH      = DIFF_WIDTH + GAIN_WIDTH;
	localparam int DIV_CNT_WIDTH   = $clog2(GAIN_BITS);
	localparam int CFG_INDEX_WIDTH = 8;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE     = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE = CFG_INDEX_WIDTH'(1);

	localparam logic [VALUE_WIDTH-1:0] Q_RESET   = VALUE_WIDTH'(655);
	localparam logic [VALUE_WIDTH-1:0] R_RESET   = VALUE_WIDTH'(65536);
	localparam logic [VALUE_WIDTH-1:0] COV_ONE   = VALUE_WIDTH'(64'd1 << FRAC_BITS);
	localparam logic [GAIN_WIDTH-1:0]  GAIN_ONE  = {1'b1, {GAIN_BITS{1'b0}}};
	localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(GAIN_BITS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PRED = 7'b0000010,
		S_DEN  = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_MULE = 7'b0010000,
		S_MULC = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic pred;
		logic den;
		logic div_step;
		logic mul_est;
		logic mul_cov;
		logic finish;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/scalar_kalman_filter.sv
// One-dimensional Kalman filter with a constant-state model, Q16.16 fixed point.
// Sample channel: sample_valid/sample_ready carry one signed Q16.16 sample per
// request. Estimate channel: estimate_valid/estimate_ready return one filtered
// signed Q16.16 estimate per sample, in order.
// Config channel: cfg_valid/cfg_ready (always ready) write cfg_data to register
// cfg_index: 0 is process noise q, 1 is measurement noise r (unsigned Q16.16).
// Other indexes are ignored. Write only while the filter is idle.
// The gain comes from a restoring divider that yields one quotient bit per cycle,
// followed by two multiplications into one shared product register. A new sample
// is accepted only when the filter is idle, once the previous one has finished.
// A finished estimate sits in an output register, so the next sample is taken
// while it waits; if the receiver stalls, the following result holds in its
// final step until the output register frees up.
// Reset: estimate 0, covariance 1.0, q = 655, r = 1.0, no result pending.
`default_nettype none

module scalar_kalman_filter (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      sample_valid,
	output logic                                           sample_ready,
	input  wire logic signed [skf_pkg::VALUE_WIDTH-1:0]    sample,
	output logic                                           estimate_valid,
	input  wire logic                                      estimate_ready,
	output logic signed [skf_pkg::VALUE_WIDTH-1:0]         estimate,
	input  wire logic                                      cfg_valid,
	output logic                                           cfg_ready,
	input  wire logic [skf_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
	input  wire logic [skf_pkg::VALUE_WIDTH-1:0]           cfg_data
);

	skf_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	skf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.estimate_valid (estimate_valid),
		.estimate_ready (estimate_ready),
		.cmd            (cmd)
	);

	skf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (sample),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.estimate  (estimate)
	);

endmodule

`default_nettype wire

FILE: src/skf_ctrl.sv
`default_nettype none

module skf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_ready,
	output logic               estimate_valid,
	input  wire logic          estimate_ready,
	output skf_pkg::cmd_t      cmd
);

	skf_pkg::state_t state_q, state_d;
	logic [skf_pkg::DIV_CNT_WIDTH-1:0] cnt_q;
	logic valid_q;
	logic out_free;

	assign out_free       = !valid_q || estimate_ready;
	assign sample_ready   = (state_q == skf_pkg::S_IDLE);
	assign estimate_valid = valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			skf_pkg::S_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = skf_pkg::S_PRED;
				end
			end
			skf_pkg::S_PRED: begin
				cmd.pred = 1'b1;
				state_d  = skf_pkg::S_DEN;
			end
			skf_pkg::S_DEN: begin
				cmd.den = 1'b1;
				state_d = skf_pkg::S_DIV;
			end
			skf_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == skf_pkg::DIV_LAST) begin
					state_d = skf_pkg::S_MULE;
				end
			end
			skf_pkg::S_MULE: begin
				cmd.mul_est = 1'b1;
				state_d     = skf_pkg::S_MULC;
			end
			skf_pkg::S_MULC: begin
				cmd.mul_cov = 1'b1;
				state_d     = skf_pkg::S_OUT;
			end
			skf_pkg::S_OUT: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = skf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::S_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.den) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (estimate_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/skf_datapath.sv
`default_nettype none

module skf_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire skf_pkg::cmd_t                         cmd,
	input  wire logic signed [skf_pkg::VALUE_WIDTH-1:0] sample,
	input  wire logic                                  cfg_we,
	input  wire logic [skf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [skf_pkg::VALUE_WIDTH-1:0]       cfg_data,
	output logic signed [skf_pkg::VALUE_WIDTH-1:0]     estimate
);

	localparam int VW = skf_pkg::VALUE_WIDTH;
	localparam int DW = skf_pkg::DIFF_WIDTH;
	localparam int GW = skf_pkg::GAIN_WIDTH;
	localparam int GB = skf_pkg::GAIN_BITS;
	localparam int PW = skf_pkg::PROD_WIDTH;

	logic [VW-1:0] q_q, r_q;
	logic [VW-1:0] est_q;
	logic [VW-1:0] cov_q;
	logic [VW-1:0] smp_q;
	logic [VW-1:0] pmid_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [GB-1:0] quo_q;
	logic [DW-1:0] mag_q;
	logic          neg_q;
	logic [PW-1:0] prod_q;
	logic [VW-1:0] out_q;

	logic [DW-1:0] pmid_sum;
	logic [VW-1:0] pmid_sat;
	logic [DW-1:0] diff;
	logic [DW-1:0] diff_mag;
	logic [DW:0]   rem_sh;
	logic          rem_ge;
	logic [DW:0]   rem_sub;
	logic [GW-1:0] gain;
	logic [GW-1:0] cov_factor;
	logic [DW-1:0] step;
	logic [DW-1:0] est_ext;
	logic [DW-1:0] est_next;

	always_comb begin
		pmid_sum   = {1'b0, cov_q} + {1'b0, q_q};
		pmid_sat   = pmid_sum[VW] ? '1 : pmid_sum[VW-1:0];
		diff       = {smp_q[VW-1], smp_q} - {est_q[VW-1], est_q};
		diff_mag   = diff[DW-1] ? (DW'(0) - diff) : diff;
		rem_sh     = {rem_q, 1'b0};
		rem_ge     = (rem_sh >= {1'b0, den_q});
		rem_sub    = rem_sh - {1'b0, den_q};
		gain       = (r_q == '0) ? skf_pkg::GAIN_ONE : {1'b0, quo_q};
		cov_factor = skf_pkg::GAIN_ONE - gain;
		step       = prod_q[GB +: DW];
		est_ext    = {est_q[VW-1], est_q};
		est_next   = neg_q ? (est_ext - step) : (est_ext + step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q   <= skf_pkg::Q_RESET;
			r_q   <= skf_pkg::R_RESET;
			est_q <= '0;
			cov_q <= skf_pkg::COV_ONE;
		end else begin
			if (cfg_we && (cfg_index == skf_pkg::REG_PROCESS_NOISE)) begin
				q_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == skf_pkg::REG_MEASUREMENT_NOISE)) begin
				r_q <= cfg_data;
			end
			if (cmd.mul_cov) begin
				est_q <= est_next[VW-1:0];
			end
			if (cmd.finish) begin
				cov_q <= prod_q[GB +: VW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= sample;
		end
		if (cmd.pred) begin
			pmid_q <= pmid_sat;
			mag_q  <= diff_mag;
			neg_q  <= diff[DW-1];
		end
		if (cmd.den) begin
			den_q <= {1'b0, pmid_q} + {1'b0, r_q};
			rem_q <= {1'b0, pmid_q};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[GB-2:0], rem_ge};
		end
		if (cmd.mul_est) begin
			prod_q <= PW'(mag_q) * PW'(gain);
		end
		if (cmd.mul_cov) begin
			prod_q <= PW'(pmid_q) * PW'(cov_factor);
		end
		if (cmd.finish) begin
			out_q <= est_q;
		end
	end

	assign estimate = out_q;

endmodule

`default_nettype wire
